FILE: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, status codes and types of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int LEVELS     = $clog2(NUM_BLOCKS);
    localparam int TREE_NODES = 2 * NUM_BLOCKS - 1;
    localparam int NODE_W     = $clog2(TREE_NODES);
    localparam int MASK_W     = LEVELS + 1;
    localparam int LVL_W      = $clog2(LEVELS + 1);
    localparam int POOL_W     = 32 + LEVELS;
    localparam int PADDR_W    = 3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [1:0] ST_BAD_REQUEST = 2'd2;
    localparam logic [1:0] ST_NOTHING     = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_BLOCK_SHIFT = PADDR_W'(0);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        node_t rd_addr;
        node_t wr_addr;
        logic  mask_we;
        mask_t mask_wdata;
        logic  mark_we;
        logic  mark_wdata;
    } mem_req_t;

endpackage

FILE: hw/rtl/bba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba request and response channels
// valid/ready channels carrying allocate/free requests and their results
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] request_bytes;
    logic [31:0] free_offset;

    modport source (output valid, action, request_bytes, free_offset, input ready);
    modport sink (input valid, action, request_bytes, free_offset, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] block_offset;

    modport source (output valid, status, block_offset, input ready);
    modport sink (input valid, status, block_offset, output ready);
endinterface

FILE: hw/rtl/bba_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cfg
// apb register file holding the block size shift
// ----------------------------------------------------------------------------
module bba_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [4:0]                   block_shift
);
    import bba_pkg::*;

    logic [4:0] shift_reg;
    logic       hit;

    // registers are decoded on the word index only
    assign hit    = (paddr[PADDR_W-1:2] == ADDR_BLOCK_SHIFT[PADDR_W-1:2]);
    assign pready = 1'b1;
    assign prdata = hit ? {27'd0, shift_reg} : 32'd0;
    assign block_shift = shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 5'd6;
        end
        else if (psel && penable && pwrite && hit)
        begin
            shift_reg <= pwdata[4:0];
        end
    end

endmodule

FILE: hw/rtl/bba_tree_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_tree_mem
// node storage: free size masks and allocated marks, registered read
// ----------------------------------------------------------------------------
module bba_tree_mem (
    input  logic              clk,
    input  bba_pkg::mem_req_t req,
    output bba_pkg::mask_t    mask_rd,
    output logic              mark_rd
);
    import bba_pkg::*;

    mask_t mask_mem [TREE_NODES];
    logic  mark_mem [TREE_NODES];

    always_ff @(posedge clk)
    begin
        if (req.mask_we)
        begin
            mask_mem[req.wr_addr] <= req.mask_wdata;
        end
        mask_rd <= mask_mem[req.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.mark_we)
        begin
            mark_mem[req.wr_addr] <= req.mark_wdata;
        end
        mark_rd <= mark_mem[req.rd_addr];
    end

endmodule

FILE: hw/rtl/bba_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_seq
// request sequencer: clearing sweep, size search, tree descent, free walk and mask rebuild
// ----------------------------------------------------------------------------
module bba_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         block_shift,
    input  bba_pkg::mask_t     mask_rd,
    input  logic               mark_rd,
    output bba_pkg::mem_req_t  mreq,
    bba_req_if.sink            req,
    bba_rsp_if.source          rsp
);
    import bba_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_DESC  = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_FWALK = 4'd6;
    localparam logic [3:0] S_UP    = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic             action_reg, action_next;
    logic [31:0]      bytes_reg, bytes_next;
    logic [LVL_W-1:0] e_reg, e_next;
    logic [LVL_W-1:0] d_reg, d_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    node_t            node_reg, node_next;
    mask_t            vm_reg, vm_next;
    mask_t            cur_reg, cur_next;
    logic [1:0]       st_reg, st_next;
    logic [31:0]      offs_reg, offs_next;
    logic             ovalid_reg, ovalid_next;
    logic [1:0]       ostatus_reg, ostatus_next;
    logic [31:0]      ooffs_reg, ooffs_next;

    logic [POOL_W-1:0] pool;
    logic [POOL_W-1:0] unit;
    node_t             parent, sibling, left, pick, idx, blk;
    mask_t             vm_up, merged;
    logic [MASK_W:0]   full_here;

    assign pool      = POOL_W'(NUM_BLOCKS) << block_shift;
    assign unit      = POOL_W'(1) << (6'(e_reg) + 6'(block_shift));
    assign parent    = (node_reg - node_t'(1)) >> 1;
    assign sibling   = node_reg[0] ? node_reg + node_t'(1) : node_reg - node_t'(1);
    assign left      = {node_reg[NODE_W-2:0], 1'b1};
    assign pick      = mask_rd[e_reg] ? left : left + node_t'(1);
    assign idx       = node_reg + node_t'(1) - (node_t'(1) << d_reg);
    assign blk       = idx << e_reg;
    assign vm_up     = vm_reg << 1;
    assign full_here = ({1'b0, vm_reg} << 1) - (MASK_W+1)'(1);
    // a free merges two wholly free buddies into one larger free block
    assign merged    = (!action_reg) ? (cur_reg | mask_rd)
                     : ((cur_reg == vm_up - mask_t'(1)) && (mask_rd == vm_up - mask_t'(1)))
                       ? mask_t'(({1'b0, vm_up} << 1) - (MASK_W+1)'(1))
                       : (cur_reg | mask_rd);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.block_offset = ooffs_reg;

    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        bytes_next   = bytes_reg;
        e_next       = e_reg;
        d_next       = d_reg;
        lvl_next     = lvl_reg;
        node_next    = node_reg;
        vm_next      = vm_reg;
        cur_next     = cur_reg;
        st_next      = st_reg;
        offs_next    = offs_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        ostatus_next = ostatus_reg;
        ooffs_next   = ooffs_reg;
        mreq         = '0;
        mreq.wr_addr = node_reg;

        case (state_reg)
            S_INIT:
            begin
                // clearing sweep, cur holds the full mask of the current level
                mreq.mask_we    = 1'b1;
                mreq.mask_wdata = cur_reg;
                mreq.mark_we    = 1'b1;
                mreq.mark_wdata = 1'b0;
                if (((node_reg + node_t'(2)) & (node_reg + node_t'(1))) == node_t'(0))
                begin
                    cur_next = cur_reg >> 1;
                end
                node_next = node_reg + node_t'(1);
                if (node_reg == node_t'(TREE_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = req.action;
                    bytes_next  = req.request_bytes;
                    offs_next   = 32'd0;
                    vm_next     = mask_t'(1);
                    e_next      = '0;
                    if (req.action)
                    begin
                        if ({{LEVELS{1'b0}}, req.free_offset} >= pool)
                        begin
                            st_next    = ST_BAD_REQUEST;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            node_next    = node_t'(NUM_BLOCKS - 1)
                                         + node_t'(req.free_offset >> block_shift);
                            mreq.rd_addr = node_t'(NUM_BLOCKS - 1)
                                         + node_t'(req.free_offset >> block_shift);
                            state_next   = S_FWALK;
                        end
                    end
                    else if (req.request_bytes == 32'd0
                             || {{LEVELS{1'b0}}, req.request_bytes} > pool)
                    begin
                        st_next    = ST_BAD_REQUEST;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SIZE;
                    end
                end
            end
            S_SIZE:
            begin
                // smallest power-of-two block count covering the request
                if (unit >= {{LEVELS{1'b0}}, bytes_reg})
                begin
                    d_next       = LVL_W'(LEVELS) - e_reg;
                    node_next    = '0;
                    mreq.rd_addr = '0;
                    state_next   = S_ROOT;
                end
                else
                begin
                    e_next = e_reg + LVL_W'(1);
                end
            end
            S_ROOT:
            begin
                if (!mask_rd[e_reg])
                begin
                    st_next    = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else if (d_reg == '0)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    mreq.rd_addr = left;
                    lvl_next     = '0;
                    state_next   = S_DESC;
                end
            end
            S_DESC:
            begin
                node_next = pick;
                lvl_next  = lvl_reg + LVL_W'(1);
                if (lvl_reg + LVL_W'(1) == d_reg)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    mreq.rd_addr = {pick[NODE_W-2:0], 1'b1};
                end
            end
            S_MARK:
            begin
                mreq.mask_we    = 1'b1;
                mreq.mask_wdata = '0;
                mreq.mark_we    = 1'b1;
                mreq.mark_wdata = 1'b1;
                cur_next        = '0;
                offs_next       = 32'((POOL_W'(blk) << block_shift));
                st_next         = ST_OK;
                mreq.rd_addr    = sibling;
                state_next      = (node_reg == '0) ? S_DONE : S_UP;
            end
            S_FWALK:
            begin
                if (mark_rd)
                begin
                    mreq.mask_we    = 1'b1;
                    mreq.mask_wdata = mask_t'(full_here);
                    mreq.mark_we    = 1'b1;
                    mreq.mark_wdata = 1'b0;
                    cur_next        = mask_t'(full_here);
                    st_next         = ST_OK;
                    mreq.rd_addr    = sibling;
                    state_next      = (node_reg == '0) ? S_DONE : S_UP;
                end
                else if (node_reg == '0)
                begin
                    st_next    = ST_NOTHING;
                    state_next = S_DONE;
                end
                else
                begin
                    node_next    = parent;
                    vm_next      = vm_up;
                    mreq.rd_addr = parent;
                end
            end
            S_UP:
            begin
                // sibling mask is on the read port, rebuild the parent
                mreq.wr_addr    = parent;
                mreq.mask_we    = 1'b1;
                mreq.mask_wdata = merged;
                cur_next        = merged;
                vm_next         = vm_up;
                node_next       = parent;
                mreq.rd_addr    = parent[0] ? parent + node_t'(1) : parent - node_t'(1);
                if (parent == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = st_reg;
                    ooffs_next   = offs_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            node_reg   <= '0;
            cur_reg    <= {MASK_W{1'b1}};
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            node_reg   <= node_next;
            cur_reg    <= cur_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        bytes_reg   <= bytes_next;
        e_reg       <= e_next;
        d_reg       <= d_next;
        lvl_reg     <= lvl_next;
        vm_reg      <= vm_next;
        st_reg      <= st_next;
        offs_reg    <= offs_next;
        ostatus_reg <= ostatus_next;
        ooffs_reg   <= ooffs_next;
    end

endmodule

FILE: hw/rtl/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator over a binary tree of free size masks in on-chip memory
// ----------------------------------------------------------------------------
// requests: one at a time, the next taken only once the result is registered;
//   each tree level costs one memory access down and one going up
// reset: a clearing pass over all 2*NUM_BLOCKS-1 (511) tree nodes rebuilds the
//   tree before the first request is taken; block_shift resets to 6
module buddy_block_allocator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bba_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp
);
    import bba_pkg::*;

    logic [4:0] block_shift;
    mem_req_t   mreq;
    mask_t      mask_rd;
    logic       mark_rd;

    bba_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .block_shift (block_shift)
    );

    bba_tree_mem u_mem (
        .clk     (clk),
        .req     (mreq),
        .mask_rd (mask_rd),
        .mark_rd (mark_rd)
    );

    bba_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_shift (block_shift),
        .mask_rd     (mask_rd),
        .mark_rd     (mark_rd),
        .mreq        (mreq),
        .req         (req),
        .rsp         (rsp)
    );

    // a failed request never carries an offset
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.block_offset == 32'd0)
        else $error("offset on failed request");

    // one request in flight: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");

    // the mask and mark writes that mark a node allocated never collide with a read of that node
    assert property (@(posedge clk) disable iff (!rst_n)
        mreq.mask_we && mreq.mark_we && mreq.mark_wdata |-> mreq.rd_addr != mreq.wr_addr)
        else $error("read of node being marked");

endmodule
